// File: hdl/atlc_pkg.sv
// shared types and constants for the adaptive traffic light controller
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package atlc_pkg;

  typedef enum logic [2:0] {
    PH_NS_GREEN  = 3'd0,
    PH_NS_YELLOW = 3'd1,
    PH_EW_GREEN  = 3'd2,
    PH_EW_YELLOW = 3'd3,
    PH_WALK      = 3'd4
  } phase_t;

  localparam logic [1:0] LAMP_RED    = 2'd0;
  localparam logic [1:0] LAMP_YELLOW = 2'd1;
  localparam logic [1:0] LAMP_GREEN  = 2'd2;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int SECS_W     = 10;
  localparam int TPS_W      = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_BASE_GREEN = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_YELLOW     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_WALK       = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_TPS        = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_LEVEL1     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_LEVEL2     = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_LEVEL3     = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_STEP       = 3'd7;

  typedef struct packed {
    logic [7:0]       base_green_secs;
    logic [7:0]       yellow_secs;
    logic [7:0]       walk_secs;
    logic [TPS_W-1:0] ticks_per_second;
    logic [7:0]       level1_threshold;
    logic [7:0]       level2_threshold;
    logic [7:0]       level3_threshold;
    logic [7:0]       extra_step_secs;
  } cfg_t;

  // fixed-width part of one result word
  typedef struct packed {
    logic [SECS_W-1:0] green_extra_secs;
    logic [SECS_W-1:0] secs_remaining;
    phase_t            phase_now;
    logic              walk_lamp;
    logic [1:0]        ew_lamp;
    logic [1:0]        ns_lamp;
  } res_t;

  localparam int RES_W = $bits(res_t);

endpackage

// File: hdl/atlc_cfg_regs.sv
// configuration register file of the traffic light controller
// depends on atlc_pkg
`timescale 1ns / 1ps

module atlc_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [atlc_pkg::CFG_ADDR_W-1:0] wr_addr,
  input  logic [atlc_pkg::CFG_DATA_W-1:0] wr_data,
  output atlc_pkg::cfg_t                  cfg
);
  import atlc_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_green_secs  <= 8'd10;
      cfg_r.yellow_secs      <= 8'd3;
      cfg_r.walk_secs        <= 8'd8;
      cfg_r.ticks_per_second <= 16'd50;
      cfg_r.level1_threshold <= 8'd5;
      cfg_r.level2_threshold <= 8'd10;
      cfg_r.level3_threshold <= 8'd15;
      cfg_r.extra_step_secs  <= 8'd10;
    end else if (wr_en) begin
      unique case (wr_addr)
        REG_BASE_GREEN: cfg_r.base_green_secs  <= wr_data[7:0];
        REG_YELLOW:     cfg_r.yellow_secs      <= wr_data[7:0];
        REG_WALK:       cfg_r.walk_secs        <= wr_data[7:0];
        REG_TPS:        cfg_r.ticks_per_second <= wr_data[TPS_W-1:0];
        REG_LEVEL1:     cfg_r.level1_threshold <= wr_data[7:0];
        REG_LEVEL2:     cfg_r.level2_threshold <= wr_data[7:0];
        REG_LEVEL3:     cfg_r.level3_threshold <= wr_data[7:0];
        REG_STEP:       cfg_r.extra_step_secs  <= wr_data[7:0];
        default:        cfg_r <= cfg_r;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: hdl/atlc_core.sv
// phase sequencer, second timer and queue counters of the controller
// depends on atlc_pkg; one button sample word per step
`timescale 1ns / 1ps

module atlc_core #(
  parameter int COUNT_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [2:0]            levels,
  input  atlc_pkg::cfg_t        cfg,
  output atlc_pkg::res_t        res_nxt,
  output logic [COUNT_BITS-1:0] ns_count_nxt,
  output logic [COUNT_BITS-1:0] ew_count_nxt,
  output logic                  walk_req_nxt
);
  import atlc_pkg::*;

  localparam int CMP_W = (COUNT_BITS > 8) ? COUNT_BITS : 8;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  phase_t                phase_r, phase_nxt, phase_s;
  logic                  started_r;
  logic [SECS_W-1:0]     secs_r, secs_nxt, secs_s;
  logic [SECS_W-1:0]     extra_r, extra_nxt, extra_s;
  logic [TPS_W-1:0]      tick_r, tick_nxt, tick_s;
  logic [COUNT_BITS-1:0] ns_count_r, ew_count_r, ns_inc, ew_inc;
  logic                  walk_req_r, walk_inc;
  logic                  walk_then_ew_r, walk_then_ew_nxt;
  logic [2:0]            last_r, falls;
  logic                  ns_red, ew_red;
  logic [SECS_W-1:0]     start_extra, green_extra;
  logic [COUNT_BITS-1:0] green_count;
  logic                  sec_done;

  // extra green seconds from the queued count, level 3 tested first
  function automatic logic [SECS_W-1:0] level_extra(input logic [COUNT_BITS-1:0] cnt,
                                                   input cfg_t c);
    logic [CMP_W-1:0]  cw;
    logic [SECS_W-1:0] step1;
    logic [SECS_W-1:0] r;
    cw    = CMP_W'(cnt);
    step1 = SECS_W'(c.extra_step_secs);
    if (cw >= CMP_W'(c.level3_threshold))      r = (step1 << 1) + step1;
    else if (cw >= CMP_W'(c.level2_threshold)) r = step1 << 1;
    else if (cw >= CMP_W'(c.level1_threshold)) r = step1;
    else                                       r = '0;
    return r;
  endfunction

  // first word after reset loads ns green
  always_comb begin
    start_extra = level_extra(ns_count_r, cfg);
    if (!started_r) begin
      phase_s = PH_NS_GREEN;
      tick_s  = '0;
      extra_s = start_extra;
      secs_s  = SECS_W'({1'b0, SECS_W'(cfg.base_green_secs)} + {1'b0, start_extra});
    end else begin
      phase_s = phase_r;
      tick_s  = tick_r;
      extra_s = extra_r;
      secs_s  = secs_r;
    end
  end

  // button edges against the current phase
  always_comb begin
    falls  = last_r & ~levels;
    ns_red = (phase_s == PH_EW_GREEN) || (phase_s == PH_EW_YELLOW) || (phase_s == PH_WALK);
    ew_red = (phase_s == PH_NS_GREEN) || (phase_s == PH_NS_YELLOW) || (phase_s == PH_WALK);
    ns_inc = ns_count_r;
    ew_inc = ew_count_r;
    if (falls[0] && ns_red && (ns_count_r != COUNT_MAX)) ns_inc = ns_count_r + 1'b1;
    if (falls[1] && ew_red && (ew_count_r != COUNT_MAX)) ew_inc = ew_count_r + 1'b1;
    walk_inc = walk_req_r | falls[2];
  end

  // green entered from yellow or walk takes the level of its own direction
  always_comb begin
    if ((phase_s == PH_NS_YELLOW) || ((phase_s == PH_WALK) && walk_then_ew_r))
      green_count = ew_inc;
    else
      green_count = ns_inc;
    green_extra = level_extra(green_count, cfg);
  end

  always_comb begin
    phase_nxt        = phase_s;
    secs_nxt         = secs_s;
    extra_nxt        = extra_s;
    ns_count_nxt     = ns_inc;
    ew_count_nxt     = ew_inc;
    walk_req_nxt     = walk_inc;
    walk_then_ew_nxt = walk_then_ew_r;
    sec_done = ({1'b0, tick_s} + 1'b1) >= {1'b0, cfg.ticks_per_second};
    if (sec_done) begin
      tick_nxt = '0;
      if (secs_s <= SECS_W'(1)) begin
        unique case (phase_s)
          PH_NS_GREEN: begin
            ns_count_nxt = '0;
            phase_nxt    = PH_NS_YELLOW;
            extra_nxt    = '0;
            secs_nxt     = SECS_W'(cfg.yellow_secs);
          end
          PH_EW_GREEN: begin
            ew_count_nxt = '0;
            phase_nxt    = PH_EW_YELLOW;
            extra_nxt    = '0;
            secs_nxt     = SECS_W'(cfg.yellow_secs);
          end
          PH_NS_YELLOW, PH_EW_YELLOW: begin
            if (walk_inc) begin
              walk_then_ew_nxt = (phase_s == PH_NS_YELLOW);
              phase_nxt        = PH_WALK;
              extra_nxt        = '0;
              secs_nxt         = SECS_W'(cfg.walk_secs);
            end else begin
              phase_nxt = (phase_s == PH_NS_YELLOW) ? PH_EW_GREEN : PH_NS_GREEN;
              extra_nxt = green_extra;
              secs_nxt  = SECS_W'({1'b0, SECS_W'(cfg.base_green_secs)} + {1'b0, green_extra});
            end
          end
          default: begin
            walk_req_nxt = 1'b0;
            phase_nxt    = walk_then_ew_r ? PH_EW_GREEN : PH_NS_GREEN;
            extra_nxt    = green_extra;
            secs_nxt     = SECS_W'({1'b0, SECS_W'(cfg.base_green_secs)} + {1'b0, green_extra});
          end
        endcase
      end else begin
        secs_nxt = secs_s - 1'b1;
      end
    end else begin
      tick_nxt = tick_s + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_NS_GREEN;
      started_r      <= 1'b0;
      secs_r         <= '0;
      extra_r        <= '0;
      tick_r         <= '0;
      ns_count_r     <= '0;
      ew_count_r     <= '0;
      walk_req_r     <= 1'b0;
      walk_then_ew_r <= 1'b0;
      last_r         <= 3'b111;
    end else if (step) begin
      phase_r        <= phase_nxt;
      started_r      <= 1'b1;
      secs_r         <= secs_nxt;
      extra_r        <= extra_nxt;
      tick_r         <= tick_nxt;
      ns_count_r     <= ns_count_nxt;
      ew_count_r     <= ew_count_nxt;
      walk_req_r     <= walk_req_nxt;
      walk_then_ew_r <= walk_then_ew_nxt;
      last_r         <= levels;
    end
  end

  // lamp decode of the state after this word
  always_comb begin
    res_nxt.phase_now      = phase_nxt;
    res_nxt.secs_remaining = secs_nxt;
    res_nxt.ns_lamp = (phase_nxt == PH_NS_GREEN) ? LAMP_GREEN :
                      (phase_nxt == PH_NS_YELLOW) ? LAMP_YELLOW : LAMP_RED;
    res_nxt.ew_lamp = (phase_nxt == PH_EW_GREEN) ? LAMP_GREEN :
                      (phase_nxt == PH_EW_YELLOW) ? LAMP_YELLOW : LAMP_RED;
    res_nxt.walk_lamp = (phase_nxt == PH_WALK);
    res_nxt.green_extra_secs =
      ((phase_nxt == PH_NS_GREEN) || (phase_nxt == PH_EW_GREEN)) ? extra_nxt : '0;
  end

endmodule

// File: hdl/adaptive_traffic_light_controller.sv
// Adaptive traffic light controller with pedestrian request.
// Each input word is one button sample tick: in_tdata[0] ns button, [1] ew button,
// [2] walk button, raw levels with 0 pressed and 1 released. Every accepted word
// gives exactly one result word on out_ with the lamps, phase, seconds left, the
// extra green granted and the queue counts as they stand after that tick.
// Settings are to be written on cfg_ (index, data) only while the block is idle;
// the block itself does not enforce this. cfg_ready is always high.
// A word waits in the input register while the phase update runs, and its result
// enters the result register when the word advances, from where out_ presents it.
// Throughput is one word per cycle while the receiver keeps up; the only loop is
// the state update itself. A new word is taken while a finished result still
// waits, so a stalled receiver holds out_ steady and back-pressure reaches
// in_tready only when both stages are full.
// Synchronous active-low reset restores the default settings, empties both
// stages and puts the sequencer before its first tick, which loads ns green.
`timescale 1ns / 1ps

module adaptive_traffic_light_controller #(
  parameter int COUNT_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // ns_button_level, ew_button_level, walk_button_level, zero fill
  input  logic [7:0]                      in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // ns_lamp, ew_lamp, walk_lamp, phase_now, secs_remaining, green_extra_secs,
  // ns_queue_count, ew_queue_count, walk_pending, zero fill
  output logic [((atlc_pkg::RES_W + 2*COUNT_BITS + 1 + 7) / 8) * 8 - 1:0] out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [atlc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [atlc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import atlc_pkg::*;

  localparam int OUT_BITS = RES_W + 2*COUNT_BITS + 1;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  cfg_t                  cfg;
  res_t                  res_nxt;
  logic [COUNT_BITS-1:0] ns_count_nxt, ew_count_nxt;
  logic                  walk_req_nxt;
  logic                  s1_valid_r;
  logic [2:0]            s1_levels_r;
  logic                  advance;
  logic                  out_valid_r;
  logic [OUT_W-1:0]      out_data_r;

  assign cfg_ready = 1'b1;

  atlc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid),
    .wr_addr (cfg_addr),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_levels_r <= in_tdata[2:0];
    end
  end

  atlc_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (advance),
    .levels       (s1_levels_r),
    .cfg          (cfg),
    .res_nxt      (res_nxt),
    .ns_count_nxt (ns_count_nxt),
    .ew_count_nxt (ew_count_nxt),
    .walk_req_nxt (walk_req_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= OUT_W'({walk_req_nxt, ew_count_nxt, ns_count_nxt, res_nxt});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: tb/adaptive_traffic_light_controller_tb.sv
// self-checking testbench for adaptive_traffic_light_controller
// keeps its own model of the phase sequencer and compares every result word field by field
// depends on atlc_pkg and the controller rtl only
`timescale 1ns / 1ps

module adaptive_traffic_light_controller_tb;
  import atlc_pkg::*;

  localparam int COUNT_BITS = 8;
  localparam int OUT_W = ((RES_W + 2*COUNT_BITS + 1 + 7) / 8) * 8;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam int STALL_LIMIT = 1000;

  // result word as it sits on out_tdata, lowest field last
  typedef struct packed {
    logic [2:0]  fill;
    logic        walk_pending;
    logic [7:0]  ew_queue;
    logic [7:0]  ns_queue;
    logic [9:0]  green_extra;
    logic [9:0]  secs_left;
    phase_t      phase_now;
    logic        walk_lamp;
    logic [1:0]  ew_lamp;
    logic [1:0]  ns_lamp;
  } light_word_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  adaptive_traffic_light_controller #(.COUNT_BITS(COUNT_BITS)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 0;
  end

  logic [7:0]  ticks_pending[$];
  light_word_t lamps_due[$];
  logic [2:0]  lv_gen = 3'b111;
  bit          quiet = 1'b0;
  int          mismatches = 0;
  int          stall_cycles = 0;

  // controller model state
  cfg_t            model_cfg = '{base_green_secs: 8'd10, yellow_secs: 8'd3, walk_secs: 8'd8,
                                 ticks_per_second: 16'd50, level1_threshold: 8'd5,
                                 level2_threshold: 8'd10, level3_threshold: 8'd15,
                                 extra_step_secs: 8'd10};
  phase_t          cur_phase = PH_NS_GREEN;
  logic            seq_started = 1'b0;
  logic [9:0]      secs_left = '0;
  logic [9:0]      extra_granted = '0;
  logic [15:0]     tick_count = '0;
  logic [7:0]      ns_queue = '0;
  logic [7:0]      ew_queue = '0;
  logic            walk_req = 1'b0;
  logic            walk_then_ew = 1'b0;
  logic [2:0]      last_levels = 3'b111;

  function automatic logic [9:0] level_bonus(input logic [7:0] count);
    logic [9:0] lvl;
    if (count >= model_cfg.level3_threshold) lvl = 10'd3;
    else if (count >= model_cfg.level2_threshold) lvl = 10'd2;
    else if (count >= model_cfg.level1_threshold) lvl = 10'd1;
    else lvl = 10'd0;
    return lvl * model_cfg.extra_step_secs;
  endfunction

  task automatic load_green(input phase_t ph, input logic [7:0] count);
    cur_phase = ph;
    extra_granted = level_bonus(count);
    secs_left = model_cfg.base_green_secs + extra_granted;
  endtask

  task automatic load_timed(input phase_t ph, input logic [7:0] secs);
    cur_phase = ph;
    extra_granted = '0;
    secs_left = {2'b00, secs};
  endtask

  task automatic advance_phase();
    case (cur_phase)
      PH_NS_GREEN: begin
        ns_queue = '0;
        load_timed(PH_NS_YELLOW, model_cfg.yellow_secs);
      end
      PH_NS_YELLOW: begin
        if (walk_req) begin
          walk_then_ew = 1'b1;
          load_timed(PH_WALK, model_cfg.walk_secs);
        end else load_green(PH_EW_GREEN, ew_queue);
      end
      PH_EW_GREEN: begin
        ew_queue = '0;
        load_timed(PH_EW_YELLOW, model_cfg.yellow_secs);
      end
      PH_EW_YELLOW: begin
        if (walk_req) begin
          walk_then_ew = 1'b0;
          load_timed(PH_WALK, model_cfg.walk_secs);
        end else load_green(PH_NS_GREEN, ns_queue);
      end
      default: begin
        walk_req = 1'b0;
        if (walk_then_ew) load_green(PH_EW_GREEN, ew_queue);
        else load_green(PH_NS_GREEN, ns_queue);
      end
    endcase
  endtask

  task automatic step_intersection(input logic [2:0] lv);
    logic [2:0]  falls;
    logic        ns_red, ew_red;
    light_word_t w;
    if (!seq_started) begin
      seq_started = 1'b1;
      tick_count = '0;
      load_green(PH_NS_GREEN, ns_queue);
    end
    falls = last_levels & ~lv;
    ns_red = cur_phase == PH_EW_GREEN || cur_phase == PH_EW_YELLOW || cur_phase == PH_WALK;
    ew_red = cur_phase == PH_NS_GREEN || cur_phase == PH_NS_YELLOW || cur_phase == PH_WALK;
    if (falls[0] && ns_red && ns_queue != COUNT_MAX) ns_queue++;
    if (falls[1] && ew_red && ew_queue != COUNT_MAX) ew_queue++;
    if (falls[2]) walk_req = 1'b1;
    last_levels = lv;
    if ({1'b0, tick_count} + 17'd1 >= {1'b0, model_cfg.ticks_per_second}) begin
      tick_count = '0;
      if (secs_left <= 10'd1) advance_phase();
      else secs_left--;
    end else begin
      tick_count++;
    end
    w = '0;
    w.ns_lamp = cur_phase == PH_NS_GREEN ? LAMP_GREEN :
                cur_phase == PH_NS_YELLOW ? LAMP_YELLOW : LAMP_RED;
    w.ew_lamp = cur_phase == PH_EW_GREEN ? LAMP_GREEN :
                cur_phase == PH_EW_YELLOW ? LAMP_YELLOW : LAMP_RED;
    w.walk_lamp = cur_phase == PH_WALK;
    w.phase_now = cur_phase;
    w.secs_left = secs_left;
    w.green_extra = (cur_phase == PH_NS_GREEN || cur_phase == PH_EW_GREEN) ? extra_granted : '0;
    w.ns_queue = ns_queue;
    w.ew_queue = ew_queue;
    w.walk_pending = walk_req;
    lamps_due.push_back(w);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      if (!in_tvalid || in_tready) begin
        if (ticks_pending.size() != 0 && (quiet || $urandom_range(99) >= 27)) begin
          in_tvalid <= 1'b1;
          in_tdata <= ticks_pending.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= quiet || $urandom_range(99) >= 27;
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin : monitor
    light_word_t want, got;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          REG_BASE_GREEN: model_cfg.base_green_secs  = cfg_data[7:0];
          REG_YELLOW:     model_cfg.yellow_secs      = cfg_data[7:0];
          REG_WALK:       model_cfg.walk_secs        = cfg_data[7:0];
          REG_TPS:        model_cfg.ticks_per_second = cfg_data;
          REG_LEVEL1:     model_cfg.level1_threshold = cfg_data[7:0];
          REG_LEVEL2:     model_cfg.level2_threshold = cfg_data[7:0];
          REG_LEVEL3:     model_cfg.level3_threshold = cfg_data[7:0];
          default:        model_cfg.extra_step_secs  = cfg_data[7:0];
        endcase
      end
      if (in_tvalid && in_tready) step_intersection(in_tdata[2:0]);
      if (out_tvalid && out_tready) begin
        got = light_word_t'(out_tdata);
        if (lamps_due.size() == 0) begin
          $display("%0t: result word with nothing expected, expected none, actual %h",
                   $time, out_tdata);
          mismatches++;
        end else begin
          want = lamps_due.pop_front();
          check_field("ns_lamp", want.ns_lamp, got.ns_lamp);
          check_field("ew_lamp", want.ew_lamp, got.ew_lamp);
          check_field("walk_lamp", want.walk_lamp, got.walk_lamp);
          check_field("phase_now", want.phase_now, got.phase_now);
          check_field("secs_remaining", want.secs_left, got.secs_left);
          check_field("green_extra_secs", want.green_extra, got.green_extra);
          check_field("ns_queue_count", want.ns_queue, got.ns_queue);
          check_field("ew_queue_count", want.ew_queue, got.ew_queue);
          check_field("walk_pending", want.walk_pending, got.walk_pending);
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic add_tick(input logic [2:0] lv);
    ticks_pending.push_back({5'b00000, lv});
  endtask

  task automatic add_random(input int n, input int flip_pct);
    for (int i = 0; i < n; i++) begin
      for (int b = 0; b < 3; b++)
        if ($urandom_range(99) < flip_pct) lv_gen[b] = ~lv_gen[b];
      add_tick(lv_gen);
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (ticks_pending.size() != 0 || in_tvalid || lamps_due.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_settings(input cfg_t c);
    write_reg(REG_BASE_GREEN, {8'd0, c.base_green_secs});
    write_reg(REG_YELLOW, {8'd0, c.yellow_secs});
    write_reg(REG_WALK, {8'd0, c.walk_secs});
    write_reg(REG_TPS, c.ticks_per_second);
    write_reg(REG_LEVEL1, {8'd0, c.level1_threshold});
    write_reg(REG_LEVEL2, {8'd0, c.level2_threshold});
    write_reg(REG_LEVEL3, {8'd0, c.level3_threshold});
    write_reg(REG_STEP, {8'd0, c.extra_step_secs});
  endtask

  initial begin
    cfg_t c;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // every button combination after all released, then held and walk presses
    for (int i = 0; i < 8; i++) begin
      add_tick(3'b111);
      add_tick(3'(i));
    end
    add_tick(3'b000);
    add_tick(3'b000);
    add_tick(3'b111);
    add_tick(3'b011);
    add_tick(3'b111);
    add_tick(3'b101);
    add_tick(3'b110);
    add_tick(3'b111);
    add_tick(3'b111);
    wait_idle();

    // zero lengths and zero ticks per second
    c = '0;
    load_settings(c);
    add_random(100, 30);
    wait_idle();

    // shortest nonzero settings, thresholds out of reach, no idling on either side
    c = '{base_green_secs: 8'd1, yellow_secs: 8'd1, walk_secs: 8'd1, ticks_per_second: 16'd1,
          level1_threshold: 8'd255, level2_threshold: 8'd255, level3_threshold: 8'd255,
          extra_step_secs: 8'd255};
    load_settings(c);
    quiet = 1'b1;
    add_random(100, 35);
    wait_idle();
    quiet = 1'b0;

    // every register at its top value
    c = '{base_green_secs: 8'd255, yellow_secs: 8'd255, walk_secs: 8'd255,
          ticks_per_second: 16'hFFFF, level1_threshold: 8'd255, level2_threshold: 8'd255,
          level3_threshold: 8'd255, extra_step_secs: 8'd255};
    load_settings(c);
    add_random(40, 40);
    wait_idle();

    // random short settings, thresholds often out of order
    for (int p = 0; p < 5; p++) begin
      c.base_green_secs  = 8'($urandom_range(0, 6));
      c.yellow_secs      = 8'($urandom_range(0, 3));
      c.walk_secs        = 8'($urandom_range(0, 3));
      c.ticks_per_second = 16'($urandom_range(0, 3));
      c.level1_threshold = 8'($urandom_range(0, 12));
      c.level2_threshold = 8'($urandom_range(0, 12));
      c.level3_threshold = 8'($urandom_range(0, 12));
      c.extra_step_secs  = 8'($urandom_range(0, 5));
      load_settings(c);
      add_random(60, (p % 2 == 0) ? 25 : 50);
      wait_idle();
    end

    // longest green, red side pressed on every other word until its count saturates
    c = '{base_green_secs: 8'd255, yellow_secs: 8'd1, walk_secs: 8'd1, ticks_per_second: 16'd1,
          level1_threshold: 8'd0, level2_threshold: 8'd0, level3_threshold: 8'd0,
          extra_step_secs: 8'd255};
    load_settings(c);
    for (int i = 0; i < 580; i++) begin
      lv_gen[1:0] = ~lv_gen[1:0];
      if ($urandom_range(99) < 5) lv_gen[2] = ~lv_gen[2];
      add_tick(lv_gen);
    end
    wait_idle();
    repeat (8) @(posedge clk);

    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
